// ===== rtl/core/pts_pkg.sv =====
// Shared types and constants for the priority thread scheduler.
// Holds the slot table geometry, event and status codes, and the payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  localparam int SLOTS = 4;
  localparam int IW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);

  // Event kinds.
  localparam logic [2:0] FN_CREATE  = 3'd0;
  localparam logic [2:0] FN_YIELD   = 3'd1;
  localparam logic [2:0] FN_EXIT    = 3'd2;
  localparam logic [2:0] FN_SETPRIO = 3'd3;
  localparam logic [2:0] FN_START   = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_NORUN  = 2'd2;

  localparam logic [1:0] PRIO_HIGH = 2'd2;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2
  } slot_state_e;

  typedef struct packed {
    slot_state_e state;
    logic [1:0]  prio;
  } slot_entry_t;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] prio_in;
  } sched_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       switched;
    logic [1:0] running_slot;
    logic [1:0] old_prio;
    logic       all_finished;
  } sched_rsp_t;

  // Read request from the scan unit to the slot table.
  typedef struct packed {
    logic          en;
    logic [IW-1:0] addr;
  } scan_rd_t;

  // Outcome of one scan over the slot table.
  typedef struct packed {
    logic          done;
    logic          found;
    logic [IW-1:0] pick;
    logic [1:0]    prio;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/priority_thread_scheduler_core.sv =====
// Top level of the priority thread scheduler: slot table, sequencer, result register.
// Depends on pts_pkg and pts_scan.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// An event transaction (create, yield, exit, set priority, start all) is taken on a
// rising edge where start is high and busy is low. Busy stays high while the event
// is worked on; exactly one result transaction follows, shown for one cycle with
// rsp_valid_o high. The receiver cannot hold results off, so it must take each one.
// Create, set priority, rejected and unknown events give their result straight after
// the table read. Yield, exit and start all search the table with one shared
// comparator, one slot per cycle, and, when a slot is found, write the chosen slot;
// a yield first puts the old slot back unless it is free. Start all with an empty
// table skips the search. The search over the slot table is what sets the worst case.
// Busy is low in the cycle the result is shown, so the next event may be accepted
// there; one event is worked on at a time.
// The slot table is a memory with one write port and a registered read port; per-entry
// valid bits make an unwritten slot read as free with priority zero.
// Reset clears the slot count, the current slot, both flags and the valid bits;
// no clearing pass is needed and an event may be accepted right after reset.

module priority_thread_scheduler_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pts_pkg::sched_req_t req_i,
  output logic                rsp_valid_o,
  output pts_pkg::sched_rsp_t rsp_o
);
  import pts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_WB_OLD,
    S_WB_PICK
  } seq_state_e;

  // Sequencer state and registered outputs.
  seq_state_e    state_q, state_d;
  logic [2:0]    func_q, func_d;
  logic [1:0]    prio_q, prio_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [CW-1:0] count_q, count_d;
  logic          started_q, started_d;
  logic          main_done_q, main_done_d;
  logic [1:0]    old_prio_q, old_prio_d;
  slot_state_e   cur_state_q, cur_state_d;
  sched_rsp_t    rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  // Slot table.
  slot_entry_t   slot_mem [SLOTS];
  logic [SLOTS-1:0] slot_vld_q;
  slot_entry_t   rd_data_q;
  logic          rd_vld_q;
  slot_entry_t   rd_entry;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  slot_entry_t   mem_wd;
  logic          mem_re;
  logic [IW-1:0] mem_ra;

  // Scan unit.
  logic          scan_start;
  scan_rd_t      scan_rd;
  scan_res_t     scan_res;

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A slot that was never written reads as free with priority zero.
  assign rd_entry = rd_vld_q ? rd_data_q : slot_entry_t'{state: ST_FREE, prio: 2'd0};

  pts_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .count_i (count_q),
    .entry_i (rd_entry),
    .rd_o    (scan_rd),
    .res_o   (scan_res)
  );

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    prio_d      = prio_q;
    cur_d       = cur_q;
    count_d     = count_q;
    started_d   = started_q;
    main_done_d = main_done_q;
    old_prio_d  = old_prio_q;
    cur_state_d = cur_state_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = cur_q;
    mem_wd      = rd_entry;
    mem_re      = 1'b0;
    mem_ra      = cur_q;
    scan_start  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d  = req_i.func;
          // A priority code of three saturates to high.
          prio_d  = (req_i.prio_in > PRIO_HIGH) ? PRIO_HIGH : req_i.prio_in;
          mem_re  = 1'b1;
          mem_ra  = cur_q;
          state_d = S_READ;
        end
      end

      S_READ: begin
        // The current slot's entry is now on the read port.
        old_prio_d = rd_entry.prio;
        cur_state_d = rd_entry.state;
        rsp_d.status       = STAT_OK;
        rsp_d.switched     = 1'b0;
        rsp_d.running_slot = 2'(cur_q);
        rsp_d.old_prio     = rd_entry.prio;
        rsp_d.all_finished = 1'b0;
        case (func_q)
          FN_CREATE: begin
            if (count_q == CW'(SLOTS)) begin
              rsp_d.status = STAT_REJECT;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = count_q[IW-1:0];
              mem_wd  = '{state: ST_RUNNABLE, prio: prio_q};
              count_d = count_q + CW'(1);
            end
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
          FN_YIELD: begin
            scan_start = 1'b1;
            state_d    = S_SCAN;
          end
          FN_EXIT: begin
            // Free the current slot before the search so it cannot be chosen.
            mem_we     = 1'b1;
            mem_wa     = cur_q;
            mem_wd     = '{state: ST_FREE, prio: rd_entry.prio};
            scan_start = 1'b1;
            state_d    = S_SCAN;
          end
          FN_SETPRIO: begin
            mem_we      = 1'b1;
            mem_wa      = cur_q;
            mem_wd      = '{state: rd_entry.state, prio: prio_q};
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
          FN_START: begin
            if (started_q) begin
              rsp_d.status = STAT_REJECT;
              rsp_valid_d  = 1'b1;
              state_d      = S_IDLE;
            end else begin
              started_d   = 1'b1;
              main_done_d = 1'b1;
              if (count_q == '0) begin
                rsp_valid_d = 1'b1;
                state_d     = S_IDLE;
              end else begin
                scan_start = 1'b1;
                state_d    = S_SCAN;
              end
            end
          end
          default: begin
            rsp_d.status = STAT_REJECT;
            rsp_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        mem_re = scan_rd.en;
        mem_ra = scan_rd.addr;
        if (scan_res.done) begin
          if (scan_res.found) begin
            // A yield first hands the old slot back unless it was already free.
            if ((func_q == FN_YIELD) && (cur_state_q != ST_FREE)) begin
              state_d = S_WB_OLD;
            end else begin
              state_d = S_WB_PICK;
            end
          end else begin
            rsp_d.status       = STAT_NORUN;
            rsp_d.switched     = 1'b0;
            rsp_d.running_slot = 2'(cur_q);
            rsp_d.old_prio     = old_prio_q;
            rsp_d.all_finished = (func_q == FN_EXIT) && main_done_q;
            rsp_valid_d        = 1'b1;
            state_d            = S_IDLE;
          end
        end
      end

      S_WB_OLD: begin
        mem_we  = 1'b1;
        mem_wa  = cur_q;
        mem_wd  = '{state: ST_RUNNABLE, prio: old_prio_q};
        state_d = S_WB_PICK;
      end

      S_WB_PICK: begin
        mem_we             = 1'b1;
        mem_wa             = scan_res.pick;
        mem_wd             = '{state: ST_RUNNING, prio: scan_res.prio};
        cur_d              = scan_res.pick;
        rsp_d.status       = STAT_OK;
        rsp_d.switched     = (scan_res.pick != cur_q);
        rsp_d.running_slot = 2'(scan_res.pick);
        rsp_d.old_prio     = old_prio_q;
        rsp_d.all_finished = 1'b0;
        rsp_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= '0;
      prio_q      <= '0;
      cur_q       <= '0;
      count_q     <= '0;
      started_q   <= 1'b0;
      main_done_q <= 1'b0;
      old_prio_q  <= '0;
      cur_state_q <= ST_FREE;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      prio_q      <= prio_d;
      cur_q       <= cur_d;
      count_q     <= count_d;
      started_q   <= started_d;
      main_done_q <= main_done_d;
      old_prio_q  <= old_prio_d;
      cur_state_q <= cur_state_d;
      rsp_q       <= rsp_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Valid bits stand in for clearing the table at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (mem_we) begin
      slot_vld_q[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= slot_mem[mem_ra];
      rd_vld_q  <= slot_vld_q[mem_ra];
    end
  end

`ifndef ASSERT_OFF
  a_rsp_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> rsp_valid_o)
    else $error("sequencer went idle without a result transaction");

  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(busy))
    else $error("result transaction without an event in progress");

  a_accept_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !rsp_valid_o))
    else $error("accepted event did not occupy the sequencer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("slot count exceeds table size");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pts_scan.sv =====
// Sequential best-slot search for the priority thread scheduler.
// Walks the slot table one entry per cycle with a single priority comparator.
// Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pts_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [pts_pkg::CW-1:0] count_i,
  input  pts_pkg::slot_entry_t entry_i,
  output pts_pkg::scan_rd_t   rd_o,
  output pts_pkg::scan_res_t  res_o
);
  import pts_pkg::*;

  logic          active_q;
  logic          pend_q;
  logic          found_q;
  logic [CW-1:0] idx_q;
  logic [IW-1:0] pend_idx_q;
  logic [IW-1:0] best_q;
  logic [1:0]    best_prio_q;
  logic          issue;
  logic          take;
  logic          done;

  // A read is issued for every slot below the count; its data arrives in the following cycle.
  assign issue = active_q && (idx_q < count_i);
  assign take  = pend_q && (entry_i.state == ST_RUNNABLE) &&
                 (!found_q || (entry_i.prio > best_prio_q));
  assign done  = active_q && !pend_q && !issue;

  assign rd_o.en     = issue;
  assign rd_o.addr   = idx_q[IW-1:0];
  assign res_o.done  = done;
  assign res_o.found = found_q;
  assign res_o.pick  = best_q;
  assign res_o.prio  = best_prio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      pend_idx_q  <= '0;
      best_q      <= '0;
      best_prio_q <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      idx_q    <= '0;
    end else if (active_q) begin
      pend_q <= issue;
      if (issue) begin
        idx_q      <= idx_q + CW'(1);
        pend_idx_q <= idx_q[IW-1:0];
      end
      if (take) begin
        found_q     <= 1'b1;
        best_q      <= pend_idx_q;
        best_prio_q <= entry_i.prio;
      end
      if (done) begin
        active_q <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && found_q) |-> (CW'(best_q) < count_i))
    else $error("scan picked a slot beyond the slot count");

  a_no_read_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !rd_o.en)
    else $error("scan issued a read while idle");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (idx_q <= count_i))
    else $error("scan index ran past the slot count");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for priority_thread_scheduler_core.
// It predicts each scheduling result in a scoreboard class and checks it against the strobed output.
// It depends on pts_pkg and the core RTL only.
`timescale 1ns / 1ps

// Scoreboard: mirrors the slot table and flags, and queues one expected result per event.
class sched_scoreboard;
  pts_pkg::slot_state_e slot_st[pts_pkg::SLOTS];
  logic [1:0]           slot_pr[pts_pkg::SLOTS];
  int unsigned          slot_cnt;
  int unsigned          cur_slot;
  bit                   started;
  bit                   main_done;
  pts_pkg::sched_rsp_t  pending_rsps[$];
  int unsigned          errors;

  function new();
    for (int i = 0; i < pts_pkg::SLOTS; i++) begin
      slot_st[i] = pts_pkg::ST_FREE;
      slot_pr[i] = 2'd0;
    end
    slot_cnt  = 0;
    cur_slot  = 0;
    started   = 1'b0;
    main_done = 1'b0;
    errors    = 0;
  endfunction

  // Highest priority runnable slot among the created ones; the lowest index wins a tie.
  function bit find_best(output int unsigned pick);
    bit found;
    found = 1'b0;
    pick  = 0;
    for (int unsigned i = 0; i < slot_cnt && i < pts_pkg::SLOTS; i++) begin
      if (slot_st[i] == pts_pkg::ST_RUNNABLE && (!found || slot_pr[i] > slot_pr[pick])) begin
        pick  = i;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function void make_running(int unsigned idx);
    slot_st[idx] = pts_pkg::ST_RUNNING;
    cur_slot     = idx;
  endfunction

  // Applies one accepted event to the mirrored state and queues the result it causes.
  function void note_event(pts_pkg::sched_req_t req);
    int unsigned         prev;
    int unsigned         pick;
    logic [1:0]          prio;
    pts_pkg::sched_rsp_t rsp;
    prev = cur_slot;
    prio = (req.prio_in > pts_pkg::PRIO_HIGH) ? pts_pkg::PRIO_HIGH : req.prio_in;
    rsp          = '0;
    rsp.status   = pts_pkg::STAT_OK;
    rsp.old_prio = slot_pr[prev];
    case (req.func)
      pts_pkg::FN_CREATE: begin
        if (slot_cnt >= pts_pkg::SLOTS) begin
          rsp.status = pts_pkg::STAT_REJECT;
        end else begin
          slot_pr[slot_cnt] = prio;
          slot_st[slot_cnt] = pts_pkg::ST_RUNNABLE;
          slot_cnt++;
        end
      end
      pts_pkg::FN_YIELD: begin
        if (!find_best(pick)) begin
          rsp.status = pts_pkg::STAT_NORUN;
        end else begin
          if (slot_st[prev] != pts_pkg::ST_FREE) slot_st[prev] = pts_pkg::ST_RUNNABLE;
          make_running(pick);
        end
      end
      pts_pkg::FN_EXIT: begin
        slot_st[prev] = pts_pkg::ST_FREE;
        if (!find_best(pick)) begin
          rsp.status       = pts_pkg::STAT_NORUN;
          rsp.all_finished = main_done;
        end else begin
          make_running(pick);
        end
      end
      pts_pkg::FN_SETPRIO: begin
        slot_pr[prev] = prio;
      end
      pts_pkg::FN_START: begin
        if (started) begin
          rsp.status = pts_pkg::STAT_REJECT;
        end else begin
          started = 1'b1;
          if (slot_cnt > 0) begin
            if (find_best(pick)) make_running(pick);
            else rsp.status = pts_pkg::STAT_NORUN;
          end
          main_done = 1'b1;
        end
      end
      default: begin
        rsp.status = pts_pkg::STAT_REJECT;
      end
    endcase
    rsp.switched     = (cur_slot != prev);
    rsp.running_slot = 2'(cur_slot);
    pending_rsps.push_back(rsp);
  endfunction

  function void cmp_field(string name, logic [2:0] exp_v, logic [2:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Compares a strobed result with the oldest expectation.
  function void check_rsp(pts_pkg::sched_rsp_t got);
    pts_pkg::sched_rsp_t exp_rsp;
    if (pending_rsps.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    exp_rsp = pending_rsps.pop_front();
    cmp_field("status", 3'(exp_rsp.status), 3'(got.status));
    cmp_field("switched", 3'(exp_rsp.switched), 3'(got.switched));
    cmp_field("running_slot", 3'(exp_rsp.running_slot), 3'(got.running_slot));
    cmp_field("old_prio", 3'(exp_rsp.old_prio), 3'(got.old_prio));
    cmp_field("all_finished", 3'(exp_rsp.all_finished), 3'(got.all_finished));
  endfunction
endclass

module tb;
  import pts_pkg::*;

  localparam int NUM_RANDOM  = 800;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_TAIL  = SLOTS + 6;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  sched_req_t req_i;
  logic       rsp_valid_o;
  sched_rsp_t rsp_o;

  sched_scoreboard sb;
  int unsigned     idle_cycles;

  priority_thread_scheduler_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Monitor: an event transaction is taken when start is high and busy is low; a result
  // transaction is taken whenever the strobe is high. Both are sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_event(req_i);
      if (rsp_valid_o) sb.check_rsp(rsp_o);
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Yield and set priority dominate so the table keeps changing; create, exit and start
  // all are kept rare because they use up the table for the rest of the run.
  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(0, 999);
    if (r < 12) return FN_CREATE;
    if (r < 30) return FN_EXIT;
    if (r < 40) return FN_START;
    if (r < 70) return 3'($urandom_range(5, 7));
    if (r < 530) return FN_YIELD;
    return FN_SETPRIO;
  endfunction

  // Drives one event after a gap and returns once the block has taken it. While start is
  // low the request carries random noise.
  task automatic send_event(input logic [2:0] func, input logic [1:0] prio, input int gap);
    sched_req_t req;
    req.func    = func;
    req.prio_in = prio;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= sched_req_t'($bits(sched_req_t)'($urandom));
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int gap;
    sb          = new();
    idle_cycles = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty table, priority saturation, unknown kinds and start all.
    send_event(FN_YIELD, 2'd0, pick_gap());    // nothing runnable
    send_event(FN_EXIT, 2'd1, pick_gap());     // nothing runnable, start not done yet
    send_event(FN_SETPRIO, 2'd3, pick_gap());  // priority three saturates to high
    send_event(FN_SETPRIO, 2'd1, pick_gap());
    send_event(FN_CREATE, 2'd3, pick_gap());
    send_event(FN_CREATE, 2'd0, pick_gap());
    send_event(3'd5, 2'd2, pick_gap());
    send_event(3'd6, 2'd1, pick_gap());
    send_event(3'd7, 2'd3, pick_gap());
    send_event(FN_START, 2'd0, pick_gap());
    send_event(FN_START, 2'd2, pick_gap());    // second start all is rejected
    send_event(FN_YIELD, 2'd0, pick_gap());
    send_event(FN_SETPRIO, 2'd0, pick_gap());
    send_event(FN_YIELD, 2'd1, pick_gap());    // slot 0 is the only runnable slot and has the higher priority
    send_event(FN_SETPRIO, 2'd2, 0);
    send_event(FN_CREATE, 2'd2, 0);
    send_event(FN_YIELD, 2'd3, 0);

    // Random part, with back-to-back stretches mixed in.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      gap = ((i % 200) < 40) ? 0 : pick_gap();
      send_event(pick_func(), 2'($urandom_range(0, 3)), gap);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
